@@ rtl/imbx_pkg.sv @@
`timescale 1ns / 1ps

package imbx_pkg;

  // fixed field widths of the command and result ports
  localparam int unsigned CORE_W  = 2;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 8;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the command word and read the lane state
    logic exec;  // update the lane and access the slot memory
  } imbx_ctrl_t;

endpackage

@@ rtl/imbx_ctrl.sv @@
`timescale 1ns / 1ps

module imbx_ctrl import imbx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output logic       res_valid_o,
  output imbx_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          res_valid_q <= 1'b0;
          if (start_i) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q     <= S_RESP;
          res_valid_q <= 1'b1;
        end
        S_RESP: begin
          state_q     <= S_IDLE;
          busy_q      <= 1'b0;
          res_valid_q <= 1'b0;
        end
        default: begin
          state_q     <= S_IDLE;
          busy_q      <= 1'b0;
          res_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o       = busy_q;
  assign res_valid_o  = res_valid_q;
  assign ctrl_o.load  = start_i && !busy_q;
  assign ctrl_o.exec  = (state_q == S_EXEC);

endmodule

@@ rtl/imbx_datapath.sv @@
`timescale 1ns / 1ps

module imbx_datapath import imbx_pkg::*; #(
  parameter int unsigned NUM_CORES    = 4,
  parameter int unsigned LANE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imbx_ctrl_t         ctrl_i,
  input  logic [CORE_W-1:0]  deq_core_i,
  input  logic               cmd_i,
  input  logic [CORE_W-1:0]  src_core_i,
  input  logic [CORE_W-1:0]  dst_core_i,
  input  logic [EVENT_W-1:0] event_id_i,
  input  logic [WORD_W-1:0]  payload_i,
  output logic               done_res_o,
  output logic [EVENT_W-1:0] event_out_o,
  output logic [WORD_W-1:0]  payload_out_o,
  output logic [COUNT_W-1:0] enq_total_o,
  output logic [COUNT_W-1:0] deq_total_o
);

  localparam int unsigned Lanes     = NUM_CORES * NUM_CORES;
  localparam int unsigned Slots     = Lanes * LANE_DEPTH;
  localparam int unsigned LaneW     = (Lanes > 1) ? $clog2(Lanes) : 1;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned PtrW      = $clog2(LANE_DEPTH);
  localparam int unsigned StoreBits = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(LANE_DEPTH - 1);

  typedef struct packed {
    logic [PtrW-1:0]    rd;
    logic [PtrW-1:0]    wr;
    logic [COUNT_W-1:0] enq;
    logic [COUNT_W-1:0] deq;
  } lane_t;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    ring_next = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  // lane state memory, valid bits make unwritten lanes read as zero
  lane_t             lane_mem [Lanes];
  logic [Lanes-1:0]  lane_vld_q;

  // slot storage, undefined until written
  logic [EVENT_W-1:0]   slot_ev_mem  [Slots];
  logic [StoreBits-1:0] slot_pay_mem [Slots];

  // captured command
  logic                 cmd_q;
  logic                 ok_q;
  logic [LaneW-1:0]     lane_q;
  logic [EVENT_W-1:0]   ev_q;
  logic [StoreBits-1:0] pay_q;
  lane_t                lane_rd_q;
  logic                 lane_hit_q;

  // results
  logic                 done_q;
  logic                 deq_hit_q;
  logic [COUNT_W-1:0]   enq_tot_q;
  logic [COUNT_W-1:0]   deq_tot_q;
  logic [EVENT_W-1:0]   slot_ev_q;
  logic [StoreBits-1:0] slot_pay_q;

  logic [CORE_W-1:0] dst_eff;
  logic              ok_d;
  logic [LaneW-1:0]  lane_d;
  lane_t             lane_cur;
  lane_t             lane_new;
  logic              full;
  logic              empty;
  logic              enq_ok;
  logic              deq_ok;
  logic [SlotW-1:0]  slot_addr;

  assign dst_eff = (cmd_i == CMD_DEQ) ? deq_core_i : dst_core_i;
  assign ok_d    = (int'(src_core_i) < NUM_CORES) && (int'(dst_eff) < NUM_CORES);
  assign lane_d  = LaneW'(int'(dst_eff) * NUM_CORES + int'(src_core_i));

  assign lane_cur = lane_hit_q ? lane_rd_q : '0;
  assign full     = (ring_next(lane_cur.wr) == lane_cur.rd);
  assign empty    = (lane_cur.rd == lane_cur.wr);
  assign enq_ok   = ok_q && (cmd_q == CMD_ENQ) && !full;
  assign deq_ok   = ok_q && (cmd_q == CMD_DEQ) && !empty;

  always_comb begin
    lane_new = lane_cur;
    if (enq_ok) begin
      lane_new.wr  = ring_next(lane_cur.wr);
      lane_new.enq = lane_cur.enq + 1'b1;
    end
    if (deq_ok) begin
      lane_new.rd  = ring_next(lane_cur.rd);
      lane_new.deq = lane_cur.deq + 1'b1;
    end
  end

  assign slot_addr = SlotW'(lane_q) * SlotW'(LANE_DEPTH)
                   + SlotW'((cmd_q == CMD_ENQ) ? lane_cur.wr : lane_cur.rd);

  // capture and lane read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q      <= cmd_i;
      ok_q       <= ok_d;
      lane_q     <= lane_d;
      ev_q       <= event_id_i;
      pay_q      <= payload_i[StoreBits-1:0];
      lane_rd_q  <= lane_mem[lane_d];
      lane_hit_q <= lane_vld_q[lane_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && (enq_ok || deq_ok)) begin
      lane_mem[lane_q] <= lane_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= '0;
    end else if (ctrl_i.exec && (enq_ok || deq_ok)) begin
      lane_vld_q[lane_q] <= 1'b1;
    end
  end

  // slot memory: write on enqueue, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (enq_ok) begin
        slot_ev_mem[slot_addr]  <= ev_q;
        slot_pay_mem[slot_addr] <= pay_q;
      end
      slot_ev_q  <= slot_ev_mem[slot_addr];
      slot_pay_q <= slot_pay_mem[slot_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      done_q    <= enq_ok || deq_ok;
      deq_hit_q <= deq_ok;
      enq_tot_q <= ok_q ? lane_new.enq : '0;
      deq_tot_q <= ok_q ? lane_new.deq : '0;
    end
  end

  assign done_res_o    = done_q;
  assign event_out_o   = deq_hit_q ? slot_ev_q : '0;
  assign payload_out_o = deq_hit_q ? WORD_W'(slot_pay_q) : '0;
  assign enq_total_o   = enq_tot_q;
  assign deq_total_o   = deq_tot_q;

endmodule

@@ rtl/interprocessor_mailbox_fifo.sv @@
`timescale 1ns / 1ps

// channel   | handshake              | signals
// ----------+------------------------+----------------------------------------------
// command   | start_i high, busy_o low | cmd_i src_core_i dst_core_i event_id_i payload_i
// result    | res_valid_o, one cycle | done_res_o event_out_o payload_out_o
//           |                        | enq_total_o deq_total_o
// config    | cfg_we_i               | cfg_wdata_i (dequeuing core)
//
// words are taken one at a time: the accept edge reads the lane pointers, the next
// cycle updates the lane and addresses the slot memory, and the result cycle
// then shows the result while its registered slot read is on the ports
// busy_o stays high from the accept edge until the result cycle ends
// reset clears the control, the dequeuing core and the lane valid bits; slot
// storage stays undefined until written
// the receiver cannot stall: each result is shown for exactly one cycle

module interprocessor_mailbox_fifo import imbx_pkg::*; #(
  parameter int unsigned NUM_CORES    = 4,
  parameter int unsigned LANE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CORE_W-1:0]  cfg_wdata_i,
  // command
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cmd_i,
  input  logic [CORE_W-1:0]  src_core_i,
  input  logic [CORE_W-1:0]  dst_core_i,
  input  logic [EVENT_W-1:0] event_id_i,
  input  logic [WORD_W-1:0]  payload_i,
  // result
  output logic               res_valid_o,
  output logic               done_res_o,
  output logic [EVENT_W-1:0] event_out_o,
  output logic [WORD_W-1:0]  payload_out_o,
  output logic [COUNT_W-1:0] enq_total_o,
  output logic [COUNT_W-1:0] deq_total_o
);

  // core that dequeues, selects the destination lane set for reads
  logic [CORE_W-1:0] deq_core_q;
  logic [CORE_W-1:0] deq_core_d;

  imbx_ctrl_t ctrl;

  assign deq_core_d = cfg_we_i ? cfg_wdata_i : deq_core_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deq_core_q <= '0;
    end else begin
      deq_core_q <= deq_core_d;
    end
  end

  // sequencer: accept, lane update, result
  imbx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .ctrl_o      (ctrl)
  );

  // lane pointers, counts and slot storage
  imbx_datapath #(
    .NUM_CORES    (NUM_CORES),
    .LANE_DEPTH   (LANE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .deq_core_i     (deq_core_q),
    .cmd_i          (cmd_i),
    .src_core_i     (src_core_i),
    .dst_core_i     (dst_core_i),
    .event_id_i     (event_id_i),
    .payload_i      (payload_i),
    .done_res_o     (done_res_o),
    .event_out_o    (event_out_o),
    .payload_out_o  (payload_out_o),
    .enq_total_o    (enq_total_o),
    .deq_total_o    (deq_total_o)
  );

endmodule

@@ sim/tb_interprocessor_mailbox_fifo.sv @@
`timescale 1ns / 1ps

module tb_interprocessor_mailbox_fifo;
  import imbx_pkg::*;

  localparam int unsigned NUM_CORES    = 4;
  localparam int unsigned LANE_DEPTH   = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned LANES        = NUM_CORES * NUM_CORES;

  // cycles with no word accepted and no result shown before the run is declared hung
  localparam int unsigned STALL_LIMIT  = 2000;
  // quiet cycles after the last result, covering the accept, lane update and result steps
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CHUNK_WORDS  = 150;
  // most random traffic goes through one source so its lanes see full, empty and wraps
  localparam logic [CORE_W-1:0] HOT_SRC = 2'd2;

  // sender idle percentage per random phase
  localparam int unsigned GAP_PLAN [3] = '{26, 73, 0};
  // reader core per random chunk, weighted to core 3 so its hot lane wraps its counts
  localparam int unsigned CORE_PLAN [9] = '{3, 3, 0, 3, 1, 3, 2, 3, 3};

  typedef struct packed {
    logic               done;
    logic [EVENT_W-1:0] ev;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] enq;
    logic [COUNT_W-1:0] deq;
  } mbx_reply_t;

  typedef struct packed {
    logic               cmd;
    logic [CORE_W-1:0]  src;
    logic [CORE_W-1:0]  dst;
    logic [EVENT_W-1:0] ev;
    logic [WORD_W-1:0]  word;
    logic               typed;  // reply below is typed in, not predicted
    mbx_reply_t         reply;
  } mbx_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CORE_W-1:0]  cfg_wdata_i;
  logic               start_i;
  logic               busy_o;
  logic               cmd_i;
  logic [CORE_W-1:0]  src_core_i;
  logic [CORE_W-1:0]  dst_core_i;
  logic [EVENT_W-1:0] event_id_i;
  logic [WORD_W-1:0]  payload_i;
  logic               res_valid_o;
  logic               done_res_o;
  logic [EVENT_W-1:0] event_out_o;
  logic [WORD_W-1:0]  payload_out_o;
  logic [COUNT_W-1:0] enq_total_o;
  logic [COUNT_W-1:0] deq_total_o;

  interprocessor_mailbox_fifo #(
    .NUM_CORES   (NUM_CORES),
    .LANE_DEPTH  (LANE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .src_core_i   (src_core_i),
    .dst_core_i   (dst_core_i),
    .event_id_i   (event_id_i),
    .payload_i    (payload_i),
    .res_valid_o  (res_valid_o),
    .done_res_o   (done_res_o),
    .event_out_o  (event_out_o),
    .payload_out_o(payload_out_o),
    .enq_total_o  (enq_total_o),
    .deq_total_o  (deq_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // mailbox shadow: lane storage, ring pointers, wrapping counts, reader core
  // ---------------------------------------------------------------------------
  logic [EVENT_W-1:0] lane_event [LANES][LANE_DEPTH];
  logic [WORD_W-1:0]  lane_word  [LANES][LANE_DEPTH];
  int unsigned        rd_ptr     [LANES];
  int unsigned        wr_ptr     [LANES];
  logic [COUNT_W-1:0] enq_cnt    [LANES];
  logic [COUNT_W-1:0] deq_cnt    [LANES];
  logic [CORE_W-1:0]  reader_core;

  // results owed by the block, oldest first
  mbx_reply_t lane_replies_due [$];
  mbx_row_t   dir_rows [$];

  int unsigned send_gap_pct;
  int unsigned stall_cycles;
  int unsigned n_errors, n_words, n_stored, n_taken, n_full, n_empty, n_wraps;

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= LANE_DEPTH) ? 0 : idx + 1;
  endfunction

  // one access of the shadow mailbox
  function automatic mbx_reply_t lane_access(logic cmd, logic [CORE_W-1:0] src,
                                             logic [CORE_W-1:0] dst,
                                             logic [EVENT_W-1:0] ev,
                                             logic [WORD_W-1:0] word);
    mbx_reply_t  r;
    int unsigned lane;
    int unsigned dsel;
    r = '0;
    // a dequeue always reads the lanes aimed at the reader core
    dsel = (cmd == CMD_DEQ) ? int'(reader_core) : int'(dst);
    // a core index past the last core is ignored with an all-zero result
    if (int'(src) >= NUM_CORES || dsel >= NUM_CORES) return r;
    lane = dsel * NUM_CORES + int'(src);
    if (cmd == CMD_ENQ) begin
      // one slot stays empty, so next write slot hitting the read slot means full
      if (ring_next(wr_ptr[lane]) != rd_ptr[lane]) begin
        lane_event[lane][wr_ptr[lane]] = ev;
        lane_word[lane][wr_ptr[lane]]  = word;
        wr_ptr[lane]  = ring_next(wr_ptr[lane]);
        enq_cnt[lane] = enq_cnt[lane] + 1'b1;
        if (enq_cnt[lane] == '0) n_wraps++;
        r.done = 1'b1;
        n_stored++;
      end else begin
        n_full++;
      end
    end else begin
      if (rd_ptr[lane] != wr_ptr[lane]) begin
        r.ev   = lane_event[lane][rd_ptr[lane]];
        r.word = lane_word[lane][rd_ptr[lane]];
        rd_ptr[lane]  = ring_next(rd_ptr[lane]);
        deq_cnt[lane] = deq_cnt[lane] + 1'b1;
        if (deq_cnt[lane] == '0) n_wraps++;
        r.done = 1'b1;
        n_taken++;
      end else begin
        n_empty++;
      end
    end
    // counts of the addressed lane come back on every result, hit or miss
    r.enq = enq_cnt[lane];
    r.deq = deq_cnt[lane];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  function automatic mbx_row_t mk_row(logic cmd, logic [CORE_W-1:0] src,
                                      logic [CORE_W-1:0] dst, logic [EVENT_W-1:0] ev,
                                      logic [WORD_W-1:0] word);
    mbx_row_t r;
    r      = '0;
    r.cmd  = cmd;
    r.src  = src;
    r.dst  = dst;
    r.ev   = ev;
    r.word = word;
    return r;
  endfunction

  function automatic mbx_row_t with_reply(mbx_row_t r, logic done, logic [EVENT_W-1:0] ev,
                                          logic [WORD_W-1:0] word, logic [COUNT_W-1:0] enq,
                                          logic [COUNT_W-1:0] deq);
    r.typed      = 1'b1;
    r.reply.done = done;
    r.reply.ev   = ev;
    r.reply.word = word;
    r.reply.enq  = enq;
    r.reply.deq  = deq;
    return r;
  endfunction

  // reader core is 0 throughout this table
  function automatic void load_directed();
    dir_rows = {};
    // empty lane right after reset
    dir_rows.push_back(with_reply(mk_row(CMD_DEQ, 2'd1, 2'd0, 3'd0, 32'h0),
                                  1'b0, 3'd0, 32'h0, 8'd0, 8'd0));
    // field extremes in and back out in order
    dir_rows.push_back(with_reply(mk_row(CMD_ENQ, 2'd0, 2'd0, 3'd7, 32'hffff_ffff),
                                  1'b1, 3'd0, 32'h0, 8'd1, 8'd0));
    dir_rows.push_back(with_reply(mk_row(CMD_ENQ, 2'd0, 2'd0, 3'd0, 32'h0),
                                  1'b1, 3'd0, 32'h0, 8'd2, 8'd0));
    // dst is ignored on a dequeue
    dir_rows.push_back(with_reply(mk_row(CMD_DEQ, 2'd0, 2'd3, 3'd5, 32'h1234_5678),
                                  1'b1, 3'd7, 32'hffff_ffff, 8'd2, 8'd1));
    dir_rows.push_back(with_reply(mk_row(CMD_DEQ, 2'd0, 2'd0, 3'd0, 32'h0),
                                  1'b1, 3'd0, 32'h0, 8'd2, 8'd2));
    // drained lane keeps its counts
    dir_rows.push_back(with_reply(mk_row(CMD_DEQ, 2'd0, 2'd2, 3'd0, 32'h0),
                                  1'b0, 3'd0, 32'h0, 8'd2, 8'd2));
    // highest core indices on enqueue
    dir_rows.push_back(with_reply(mk_row(CMD_ENQ, 2'd3, 2'd3, 3'd5, 32'ha5a5_a5a5),
                                  1'b1, 3'd0, 32'h0, 8'd1, 8'd0));
    // fill one lane to its depth minus one
    for (int unsigned i = 0; i < LANE_DEPTH - 1; i++) begin
      dir_rows.push_back(mk_row(CMD_ENQ, 2'd3, 2'd0, 3'(i), 32'h1000_0000 + i * 32'h0111_1111));
    end
    // lane full: nothing stored, counts unchanged
    dir_rows.push_back(with_reply(mk_row(CMD_ENQ, 2'd3, 2'd0, 3'd6, 32'h5a5a_0f0f),
                                  1'b0, 3'd0, 32'h0, 8'(LANE_DEPTH - 1), 8'd0));
    dir_rows.push_back(mk_row(CMD_DEQ, 2'd3, 2'd1, 3'd0, 32'h0));
  endfunction

  // random word, mostly aimed at the hot lane of the current reader core
  function automatic mbx_row_t rand_row(int unsigned enq_pct, bit noise);
    mbx_row_t r;
    r     = '0;
    r.cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
    r.src = CORE_W'($urandom_range(NUM_CORES - 1));
    r.dst = CORE_W'($urandom_range(NUM_CORES - 1));
    if (!noise && $urandom_range(99) < 70) begin
      r.src = HOT_SRC;
      if (r.cmd == CMD_ENQ) r.dst = reader_core;
    end
    r.ev = EVENT_W'($urandom_range(7));
    case ($urandom_range(7))
      0: r.word = '0;
      1: r.word = '1;
      default: r.word = $urandom;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------
  // random idle cycles, then hold start until the block takes the word
  task automatic send_word(input mbx_row_t r);
    mbx_reply_t due;
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i    <= 1'b1;
    cmd_i      <= r.cmd;
    src_core_i <= r.src;
    dst_core_i <= r.dst;
    event_id_i <= r.ev;
    payload_i  <= r.word;
    do @(posedge clk_i); while (busy_o);
    // accepted at this edge; the shadow advances even for typed rows
    due = lane_access(r.cmd, r.src, r.dst, r.ev, r.word);
    lane_replies_due.push_back(r.typed ? r.reply : due);
    n_words++;
  endtask

  // stop sending, let every owed result arrive, then change the reader core
  task automatic settle_and_set(input logic [CORE_W-1:0] core);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (lane_replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= core;
    reader_core  = core;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst_left;
    int unsigned enq_pct;
    bit          noise;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    cmd_i       = CMD_ENQ;
    src_core_i  = '0;
    dst_core_i  = '0;
    event_id_i  = '0;
    payload_i   = '0;
    rst_ni      = 1'b0;
    reader_core = '0;
    send_gap_pct = 0;
    foreach (rd_ptr[l]) begin
      rd_ptr[l]  = 0;
      wr_ptr[l]  = 0;
      enq_cnt[l] = '0;
      deq_cnt[l] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    settle_and_set(CORE_W'(0));
    load_directed();
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    // random part: bursts that lean toward enqueue or dequeue, with some noise
    for (int ph = 0; ph < 3; ph++) begin
      for (int ch = 0; ch < 3; ch++) begin
        send_gap_pct = GAP_PLAN[ph];
        settle_and_set(CORE_W'(CORE_PLAN[ph * 3 + ch]));
        sent       = 0;
        burst_left = 0;
        while (sent < CHUNK_WORDS) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(40, 8);
            noise      = ($urandom_range(7) == 0);
            case ($urandom_range(2))
              0: enq_pct = 85;
              1: enq_pct = 50;
              default: enq_pct = 15;
            endcase
          end
          send_word(rand_row(enq_pct, noise));
          burst_left--;
          sent++;
        end
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (lane_replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d words, %0d stored, %0d dequeued, %0d full rejects, %0d empty misses",
             n_words, n_stored, n_taken, n_full, n_empty);
    $display("run: reader cores 0 to 3, %0d lane count wraps, %0d mismatches",
             n_wraps, n_errors);
    if (n_errors == 0) begin
      $display("interprocessor_mailbox_fifo verification clean");
    end else begin
      $display("interprocessor_mailbox_fifo verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: every strobe must match the oldest owed result
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [WORD_W-1:0] due,
                              input logic [WORD_W-1:0] got);
    if (due !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, due, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    mbx_reply_t due;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (lane_replies_due.size() == 0) begin
        $display("%0t: result with none owed, expected nothing actual %0h", $time,
                 payload_out_o);
        n_errors++;
      end else begin
        due = lane_replies_due.pop_front();
        report_field("done_res", WORD_W'(due.done), WORD_W'(done_res_o));
        report_field("event_out", WORD_W'(due.ev), WORD_W'(event_out_o));
        report_field("payload_out", due.word, payload_out_o);
        report_field("enq_total", WORD_W'(due.enq), WORD_W'(enq_total_o));
        report_field("deq_total", WORD_W'(due.deq), WORD_W'(deq_total_o));
      end
    end
  end

  // hang detector: no word taken and no result shown for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("interprocessor_mailbox_fifo verification failed");
      $finish;
    end
  end

endmodule
